// File: hw/rtl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: hw/rtl/lir_pkg.sv
`default_nettype none
package lir_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int FRAC_BITS    = 32;
	localparam int PHASE_W      = 36;
	localparam int MAX_UPSAMPLE = 8;
	localparam int CNT_W        = $clog2(MAX_UPSAMPLE + 1);
	localparam int NUM_W        = SAMPLE_W + FRAC_BITS + 2;

	localparam logic [PHASE_W-1:0] ONE_UNIT  = PHASE_W'(1) << FRAC_BITS;
	localparam logic [PHASE_W-1:0] PHASE_MAX = '1;

	localparam int APB_AW      = 4;
	localparam int APB_DW      = 64;
	localparam int REG_SEL_BIT = 3;

	typedef enum logic [0:0] {
		REG_PHASE_STEP = 1'b0,
		REG_STEREO     = 1'b1
	} lir_reg_t;

	// Control that travels alongside one output point.
	typedef struct packed {
		logic valid;
		logic last;
	} lir_point_t;

endpackage
`default_nettype wire

// File: hw/rtl/lir_lane.sv
`default_nettype none
module lir_lane import lir_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [SAMPLE_W-1:0] held,
	input  logic signed [SAMPLE_W-1:0] cur,
	input  logic        [FRAC_BITS-1:0] frac,
	output logic signed [SAMPLE_W-1:0] res
);

	localparam logic signed [NUM_W-1:0] RND = NUM_W'({FRAC_BITS{1'b1}});

	logic signed [SAMPLE_W:0]    diff;
	logic signed [FRAC_BITS:0]   frac_ext;
	logic signed [NUM_W-1:0]     prod;
	logic signed [NUM_W-1:0]     prod_s1;
	logic signed [SAMPLE_W-1:0]  held_s1;
	logic signed [NUM_W-1:0]     base;
	logic signed [NUM_W-1:0]     num;
	logic signed [NUM_W-1:0]     adj;

	always_comb begin
		diff     = {cur[SAMPLE_W-1], cur} - {held[SAMPLE_W-1], held};
		frac_ext = {1'b0, frac};
		prod     = NUM_W'(diff) * NUM_W'(frac_ext);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			held_s1 <= held;
		end
	end

	// Truncate toward zero: bias negative sums by one unit less one before the shift.
	always_comb begin
		base = {{(NUM_W-SAMPLE_W-FRAC_BITS){held_s1[SAMPLE_W-1]}}, held_s1, {FRAC_BITS{1'b0}}};
		num  = base + prod_s1;
		adj  = num + (num[NUM_W-1] ? RND : '0);
		res  = adj[FRAC_BITS +: SAMPLE_W];
	end

endmodule
`default_nettype wire

// File: hw/rtl/lir_seq.sv
`default_nettype none
`include "assert_macros.svh"
module lir_seq import lir_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       block_start,
	input  logic [PHASE_W-1:0]         phase_step,
	input  logic                       stereo,
	input  logic                       adv,
	output logic                       busy,
	output lir_point_t                 pt,
	output logic [FRAC_BITS-1:0]       frac,
	output logic signed [SAMPLE_W-1:0] held_l,
	output logic signed [SAMPLE_W-1:0] held_r,
	output logic signed [SAMPLE_W-1:0] cur_l,
	output logic signed [SAMPLE_W-1:0] cur_r
);

	logic                       busy_q;
	logic                       have_held_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SAMPLE_W-1:0] held_l_q;
	logic signed [SAMPLE_W-1:0] held_r_q;
	logic signed [SAMPLE_W-1:0] cur_l_q;
	logic signed [SAMPLE_W-1:0] cur_r_q;

	logic                       accept;
	logic signed [SAMPLE_W-1:0] in_r;
	logic [PHASE_W:0]           sum;
	logic [PHASE_W-1:0]         np;
	logic                       in_range;
	logic                       cnt_last;
	logic                       issue;
	logic                       run_done;

	always_comb begin
		accept   = in_valid && !busy_q;
		in_r     = stereo ? right_sample : '0;
		sum      = {1'b0, phase_q} + {1'b0, phase_step};
		np       = sum[PHASE_W] ? PHASE_MAX : sum[PHASE_W-1:0];
		in_range = phase_q < ONE_UNIT;
		cnt_last = cnt_q == CNT_W'(MAX_UPSAMPLE - 1);
		issue    = busy_q && in_range && adv;
		run_done = (np >= ONE_UNIT) || cnt_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			have_held_q <= 1'b0;
			phase_q     <= '0;
			cnt_q       <= '0;
			held_l_q    <= '0;
			held_r_q    <= '0;
		end else if (accept) begin
			if (block_start || !have_held_q) begin
				held_l_q    <= left_sample;
				held_r_q    <= in_r;
				phase_q     <= '0;
				have_held_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (busy_q) begin
			if (!in_range) begin
				// Phase already past this interval: drop one interval, no word.
				phase_q  <= phase_q - ONE_UNIT;
				held_l_q <= cur_l_q;
				held_r_q <= cur_r_q;
				busy_q   <= 1'b0;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (run_done) begin
					phase_q  <= (np < ONE_UNIT) ? '0 : np - ONE_UNIT;
					held_l_q <= cur_l_q;
					held_r_q <= cur_r_q;
					busy_q   <= 1'b0;
				end else begin
					phase_q <= np;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_l_q <= left_sample;
			cur_r_q <= in_r;
		end
	end

	assign busy     = busy_q;
	assign pt.valid = issue;
	assign pt.last  = run_done;
	assign frac     = phase_q[FRAC_BITS-1:0];
	assign held_l   = held_l_q;
	assign held_r   = held_r_q;
	assign cur_l    = cur_l_q;
	assign cur_r    = cur_r_q;

	`ASSERT_PROP(a_issue_count, clk, arst_n, issue |-> (cnt_q < CNT_W'(MAX_UPSAMPLE)), "too many points in one run")
	`ASSERT_PROP(a_last_ends_run, clk, arst_n, (issue && run_done) |=> !busy_q, "run continues after last point")
	`ASSERT_NEVER(n_busy_without_frame, clk, arst_n, busy_q && !have_held_q, "run started with no held frame")
	`ASSERT_PROP(a_run_starts_at_zero, clk, arst_n, $rose(busy_q) |-> (cnt_q == '0), "point count not cleared at run start")

endmodule
`default_nettype wire

// File: hw/rtl/linear_interp_resampler.sv
// Linear interpolation sample rate converter.
// Input channel (in_valid/in_stall): one frame per word, left_sample, right_sample and
// block_start. Output channel (out_valid/out_stall): one interpolated frame per word,
// left_out, right_out and last_of_run, set on the final word caused by an input frame.
// Configuration over APB with 64-bit data: phase_step at address 0x0 (36 bits, 32 fraction
// bits, input rate over output rate) and stereo at 0x8. Write them only while idle.
// A frame with block_start, or the first frame after reset, only loads the held frame and
// clears the phase. Any other frame produces n words, 0 to 8. The phase sequencer issues one
// point per cycle while no stalled word holds the pipeline, and in_stall stays high until
// its run has been issued.
// Each point passes a multiply stage in the two lanes and then the output register.
// When out_stall is high with a word waiting, the lanes freeze, the sequencer issues no point
// and the word holds; a new frame can still be taken once the previous run has been issued.
// Reset clears the phase, the held frame and all valids; phase_step returns to 1.0 and
// stereo to 1. In mono, right_out is zero.
`default_nettype none
module linear_interp_resampler import lir_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_AW-1:0]          paddr,
	input  logic [APB_DW-1:0]          pwdata,
	output logic [APB_DW-1:0]          prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       block_start,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out,
	output logic                       last_of_run
);

	logic [PHASE_W-1:0]         phase_step_q;
	logic                       stereo_q;
	lir_reg_t                   reg_sel;
	logic                       cfg_wr;

	logic                       adv;
	logic                       busy;
	lir_point_t                 pt;
	lir_point_t                 pt_s1;
	logic [FRAC_BITS-1:0]       frac;
	logic signed [SAMPLE_W-1:0] held_l;
	logic signed [SAMPLE_W-1:0] held_r;
	logic signed [SAMPLE_W-1:0] cur_l;
	logic signed [SAMPLE_W-1:0] cur_r;
	logic signed [SAMPLE_W-1:0] res_l;
	logic signed [SAMPLE_W-1:0] res_r;

	logic                       out_valid_q;
	logic                       last_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_sel = lir_reg_t'(paddr[REG_SEL_BIT]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= ONE_UNIT;
			stereo_q     <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_PHASE_STEP: phase_step_q <= pwdata[PHASE_W-1:0];
				REG_STEREO:     stereo_q     <= pwdata[0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PHASE_STEP: prdata = APB_DW'(phase_step_q);
			REG_STEREO:     prdata = APB_DW'(stereo_q);
			default:        prdata = '0;
		endcase
	end

	// Whole point pipeline advances unless a word waits on a stalled receiver.
	assign adv = !(out_valid_q && out_stall);

	lir_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.block_start  (block_start),
		.phase_step   (phase_step_q),
		.stereo       (stereo_q),
		.adv          (adv),
		.busy         (busy),
		.pt           (pt),
		.frac         (frac),
		.held_l       (held_l),
		.held_r       (held_r),
		.cur_l        (cur_l),
		.cur_r        (cur_r)
	);

	assign in_stall = busy;

	lir_lane u_lane_l (
		.clk  (clk),
		.en   (adv),
		.held (held_l),
		.cur  (cur_l),
		.frac (frac),
		.res  (res_l)
	);

	lir_lane u_lane_r (
		.clk  (clk),
		.en   (adv),
		.held (held_r),
		.cur  (cur_r),
		.frac (frac),
		.res  (res_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_s1       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			pt_s1       <= pt;
			out_valid_q <= pt_s1.valid;
		end
	end

	// Merge both lanes into the output word.
	always_ff @(posedge clk) begin
		if (adv && pt_s1.valid) begin
			left_q  <= res_l;
			right_q <= stereo_q ? res_r : '0;
			last_q  <= pt_s1.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_out    = left_q;
	assign right_out   = right_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire
